// File: rtl/core/can_frame_segmenter_assert.svh
// ---------------------------------------------------------------------------
// can_frame_segmenter assertion macros
// Shared helpers for concurrent checks on the segmenter top level.
// ---------------------------------------------------------------------------
`ifndef CAN_FRAME_SEGMENTER_ASSERT_SVH
`define CAN_FRAME_SEGMENTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("can_frame_segmenter: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("can_frame_segmenter: assertion failed");

`endif

// File: rtl/core/cfs_pkg.sv
// ---------------------------------------------------------------------------
// cfs_pkg
// Types and constants for the CAN frame segmenter.
// ---------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

	// frame geometry
	localparam int FRAME_BYTES_DEF = 8;
	localparam int MAX_BYTES       = 8;

	// timing constants (timer ticks)
	localparam logic [23:0] XFER_SLOW    = 24'd9333333;
	localparam logic [23:0] XFER_FAST    = 24'd933333;
	localparam logic [23:0] PROCESS_TIME = 24'd3600000;
	localparam logic [13:0] BACKOFF_STEP = 14'd8000;

	// header codes, upper three bits of the identifier
	typedef enum logic [2:0] {
		HDR_SINGLE = 3'h1,
		HDR_FIRST  = 3'h3,
		HDR_CONT   = 3'h5,
		HDR_END    = 3'h7
	} hdr_t;

	// one finished frame as seen from the assembler
	typedef struct packed {
		logic                      emit;
		hdr_t                      hdr;
		logic [3:0]                length;
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic                      last;
	} frame_t;

endpackage

`default_nettype wire

// File: rtl/core/cfs_assembler.sv
// ---------------------------------------------------------------------------
// cfs_assembler
// Byte counter and frame store; reports a frame on the byte that closes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cfs_assembler #(
	parameter int FRAME_BYTES = cfs_pkg::FRAME_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      data_byte,
	input  wire logic [7:0]      message_length,
	output cfs_pkg::frame_t      frame
);

	localparam int SLOT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_BYTES - 1);

	logic [7:0]        pos_q;
	logic [SLOT_W-1:0] slot_q;
	logic              first_q;
	logic [7:0]        store_q [FRAME_BYTES];

	logic       active;
	logic [8:0] count;
	logic       last;
	logic       full;
	logic [3:0] slot_ext;
	logic [7:0] view [cfs_pkg::MAX_BYTES];

	// message position and end-of-frame decode
	assign active   = take && (message_length != 8'd0);
	assign count    = {1'b0, pos_q} + 9'd1;
	assign last     = count >= {1'b0, message_length};
	assign full     = slot_q == SLOT_LAST;
	assign slot_ext = 4'(slot_q);

	// counters; first_q marks a frame that starts at message byte zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			slot_q  <= '0;
			first_q <= 1'b1;
		end else if (active) begin
			if (last) begin
				pos_q   <= '0;
				slot_q  <= '0;
				first_q <= 1'b1;
			end else begin
				pos_q <= count[7:0];
				if (full) begin
					slot_q  <= '0;
					first_q <= 1'b0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	// frame store, payload only
	always_ff @(posedge clk) begin
		if (active) begin
			store_q[slot_q] <= data_byte;
		end
	end

	// frame view: earlier bytes from the store, current byte passed through
	for (genvar j = 0; j < cfs_pkg::MAX_BYTES; j++) begin : g_byte
		if (j < FRAME_BYTES) begin : g_used
			always_comb begin
				if (4'(j) < slot_ext) begin
					view[j] = store_q[j];
				end else if (4'(j) == slot_ext) begin
					view[j] = data_byte;
				end else begin
					view[j] = 8'd0;
				end
			end
		end else begin : g_unused
			always_comb begin
				view[j] = 8'd0;
			end
		end
	end

	// frame fields and header choice
	always_comb begin
		for (int j = 0; j < cfs_pkg::MAX_BYTES; j++) begin
			frame.bytes[j] = view[j];
		end
		if (last) begin
			frame.hdr = first_q ? cfs_pkg::HDR_SINGLE : cfs_pkg::HDR_END;
		end else begin
			frame.hdr = first_q ? cfs_pkg::HDR_FIRST : cfs_pkg::HDR_CONT;
		end
		frame.emit   = active && (last || full);
		frame.length = slot_ext + 4'd1;
		frame.last   = last;
	end

endmodule

`default_nettype wire

// File: rtl/core/cfs_timer.sv
// ---------------------------------------------------------------------------
// cfs_timer
// Reply timeout load: scaled reply time plus back-off, saturated to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module cfs_timer (
	input  wire logic [15:0] reply,
	input  wire logic [23:0] frame_time,
	input  wire logic [20:0] backoff,
	input  wire logic        bcast,
	input  wire logic        last,
	output logic      [31:0] load
);

	logic [39:0] prod;
	logic [40:0] total;

	// R * (transfer + processing), then unicast back-off or broadcast doubling
	assign prod = 40'(reply) * 40'(frame_time);

	always_comb begin
		if (bcast) begin
			total = {prod, 1'b0};
		end else begin
			total = {1'b0, prod} + 41'(backoff);
		end
		if (!last) begin
			load = '0;
		end else if (total[40:32] != 9'd0) begin
			load = '1;
		end else begin
			load = total[31:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/can_frame_segmenter.sv
// ---------------------------------------------------------------------------
// can_frame_segmenter
// Cuts a byte stream into CAN frames with identifier and reply timer load.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        sink       in_valid/in_ready    data_byte .. attempt_number
// out       source     out_valid/out_ready  frame_id .. timer_load
// cfg       sink       cfg_valid/cfg_ready  cfg_data (bit rate select)
//
// One input byte per cycle while in_ready is high; the byte that closes a frame
// goes through the assembler, then is registered in stage 1 and the result register.
// The timeout product is formed in the result stage from stage-1 operands.
// Reset clears the byte counter, pipeline valids and rate select; the frame
// store is not cleared. A stalled result holds while stage 1 still takes
// one more frame; in_ready drops only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "can_frame_segmenter_assert.svh"

module can_frame_segmenter #(
	parameter int FRAME_BYTES = cfs_pkg::FRAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	// input bytes
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  slave_address,
	input  wire logic [7:0]  message_length,
	input  wire logic [15:0] expected_reply_frames,
	input  wire logic [7:0]  attempt_number,
	// frames
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [10:0] frame_id,
	output logic      [3:0]  frame_length,
	output logic      [7:0]  byte0,
	output logic      [7:0]  byte1,
	output logic      [7:0]  byte2,
	output logic      [7:0]  byte3,
	output logic      [7:0]  byte4,
	output logic      [7:0]  byte5,
	output logic      [7:0]  byte6,
	output logic      [7:0]  byte7,
	output logic             last_frame,
	output logic      [31:0] timer_load
);

	logic            rate_q;
	cfs_pkg::frame_t frame;
	logic            take;
	logic            adv_s2;
	logic            adv_s1;

	logic                               v_s1;
	cfs_pkg::hdr_t                      hdr_s1;
	logic [7:0]                         slave_s1;
	logic [3:0]                         len_s1;
	logic [cfs_pkg::MAX_BYTES-1:0][7:0] bytes_s1;
	logic                               last_s1;
	logic [15:0]                        reply_s1;
	logic [23:0]                        ftime_s1;
	logic [20:0]                        backoff_s1;
	logic                               bcast_s1;

	logic [23:0] ftime;
	logic [20:0] backoff;
	logic [31:0] load;
	logic [cfs_pkg::MAX_BYTES-1:0][7:0] bytes_q;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= cfg_data;
		end
	end

	// pipeline flow control
	assign adv_s2   = !out_valid || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign take     = in_valid && in_ready;

	cfs_assembler #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_assembler (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (data_byte),
		.message_length (message_length),
		.frame          (frame)
	);

	// timer operands: frame time and attempt back-off (attempt zero counts as one)
	assign ftime   = (rate_q ? cfs_pkg::XFER_FAST : cfs_pkg::XFER_SLOW)
		+ cfs_pkg::PROCESS_TIME;
	assign backoff = (attempt_number == 8'd0) ? 21'd0
		: 21'(attempt_number - 8'd1) * 21'(cfs_pkg::BACKOFF_STEP);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= take && frame.emit;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv_s1 && take && frame.emit) begin
			hdr_s1     <= frame.hdr;
			slave_s1   <= slave_address;
			len_s1     <= frame.length;
			bytes_s1   <= frame.bytes;
			last_s1    <= frame.last;
			reply_s1   <= expected_reply_frames;
			ftime_s1   <= ftime;
			backoff_s1 <= backoff;
			bcast_s1   <= slave_address == 8'd0;
		end
	end

	cfs_timer u_timer (
		.reply      (reply_s1),
		.frame_time (ftime_s1),
		.backoff    (backoff_s1),
		.bcast      (bcast_s1),
		.last       (last_s1),
		.load       (load)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2) begin
			out_valid <= v_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			frame_id     <= {hdr_s1, slave_s1};
			frame_length <= len_s1;
			bytes_q      <= bytes_s1;
			last_frame   <= last_s1;
			timer_load   <= load;
		end
	end

	assign byte0 = bytes_q[0];
	assign byte1 = bytes_q[1];
	assign byte2 = bytes_q[2];
	assign byte3 = bytes_q[3];
	assign byte4 = bytes_q[4];
	assign byte5 = bytes_q[5];
	assign byte6 = bytes_q[6];
	assign byte7 = bytes_q[7];

	// checks
	`CFS_ASSERT_NOW(a_load_only_last, out_valid && !last_frame, timer_load == 32'd0)
	`CFS_ASSERT_NOW(a_mid_frame_full, out_valid && (frame_id[10:8] == cfs_pkg::HDR_FIRST || frame_id[10:8] == cfs_pkg::HDR_CONT), frame_length == 4'(FRAME_BYTES) && !last_frame)
	`CFS_ASSERT_NOW(a_len_range, out_valid, frame_length != 4'd0 && frame_length <= 4'(FRAME_BYTES))
	`CFS_ASSERT_NEXT(a_s1_holds, v_s1 && !adv_s2, v_s1 && out_valid)

endmodule

`default_nettype wire

// File: dv/can_frame_segmenter_tb.sv
// ---------------------------------------------------------------------------
// can_frame_segmenter testbench
// Feeds request messages byte by byte, with random bursts, gaps and output
// stalls, predicts every CAN frame with its identifier and reply timer load,
// and compares each frame that leaves the block field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	// timer ticks per event
	localparam longint unsigned XFER_100K_TICKS = 64'd9333333;
	localparam longint unsigned XFER_1M_TICKS   = 64'd933333;
	localparam longint unsigned PROC_TICKS      = 64'd3600000;
	localparam longint unsigned BACKOFF_TICKS   = 64'd8000;
	localparam longint unsigned LOAD_MAX        = 64'hFFFF_FFFF;
	localparam int              SEG_BYTES       = 8;
	localparam int              IDLE_LIMIT      = 4000;
	localparam int              SETTLE_CYCLES   = 4;
	localparam int              TAIL_CYCLES     = 10;
	localparam int              REPORT_MAX      = 10;

	// one message byte with its per-message fields
	typedef struct packed {
		logic [7:0]  data;
		logic [7:0]  slave;
		logic [7:0]  len;
		logic [15:0] reply;
		logic [7:0]  attempt;
	} seg_byte_t;

	// one CAN frame as it leaves the block
	typedef struct packed {
		logic [10:0]     id;
		logic [3:0]      length;
		logic [7:0][7:0] data;
		logic            last;
		logic [31:0]     timer;
	} frame_rec_t;

	// predicts frames from accepted bytes and checks the frames seen
	class frame_scoreboard;
		bit         rate_fast;
		logic [7:0] byte_pos;
		logic [7:0] store [SEG_BYTES];
		frame_rec_t pending_frames [$];
		int         errors;
		int         frames_seen;

		function new();
			rate_fast   = 1'b0;
			byte_pos    = 8'd0;
			errors      = 0;
			frames_seen = 0;
		endfunction

		function void set_rate(bit fast);
			rate_fast = fast;
		endfunction

		function int pending_count();
			return pending_frames.size();
		endfunction

		// reply timeout load, saturated to 32 bits
		function logic [31:0] reply_timeout(logic [7:0] slave, logic [15:0] reply,
				logic [7:0] attempt);
			longint unsigned t;
			longint unsigned a;
			t = reply;
			t = t * ((rate_fast ? XFER_1M_TICKS : XFER_100K_TICKS) + PROC_TICKS);
			a = attempt;
			if (slave != 8'd0) begin
				// attempt zero counts as the first attempt
				if (a != 0)
					t = t + (a - 1) * BACKOFF_TICKS;
			end else begin
				t = t * 2;
			end
			if (t > LOAD_MAX)
				t = LOAD_MAX;
			return t[31:0];
		endfunction

		// one accepted byte: update the frame store, queue a frame when it closes
		function void note_byte(seg_byte_t b);
			int unsigned   p, slot, fill, start, count;
			bit            last, full;
			cfs_pkg::hdr_t hdr;
			frame_rec_t    f;
			if (b.len == 8'd0)
				return;
			p     = byte_pos;
			slot  = p % SEG_BYTES;
			store[slot] = b.data;
			fill  = slot + 1;
			start = p - slot;
			count = p + 1;
			last  = (count >= b.len);
			full  = (fill >= SEG_BYTES);
			byte_pos = last ? 8'd0 : count[7:0];
			if (!last && !full)
				return;
			if (last)
				hdr = (start == 0) ? cfs_pkg::HDR_SINGLE : cfs_pkg::HDR_END;
			else
				hdr = (start == 0) ? cfs_pkg::HDR_FIRST : cfs_pkg::HDR_CONT;
			f.id     = {hdr, b.slave};
			f.length = fill[3:0];
			for (int j = 0; j < SEG_BYTES; j++)
				f.data[j] = (j < fill) ? store[j] : 8'd0;
			f.last  = last;
			f.timer = last ? reply_timeout(b.slave, b.reply, b.attempt) : 32'd0;
			pending_frames.push_back(f);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("frame %0d %s: expected 0x%0h, got 0x%0h",
						frames_seen, name, want, got);
			end
		endfunction

		function void check_frame(frame_rec_t got);
			frame_rec_t want;
			if (pending_frames.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("frame %0d: unexpected, id 0x%0h length %0d",
						frames_seen, got.id, got.length);
			end else begin
				want = pending_frames.pop_front();
				compare_field("frame_id", want.id, got.id);
				compare_field("frame_length", want.length, got.length);
				for (int j = 0; j < SEG_BYTES; j++)
					compare_field($sformatf("byte%0d", j), want.data[j], got.data[j]);
				compare_field("last_frame", want.last, got.last);
				compare_field("timer_load", want.timer, got.timer);
			end
			frames_seen++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic [7:0]  slave_address = 8'd0;
	logic [7:0]  message_length = 8'd0;
	logic [15:0] expected_reply_frames = 16'd0;
	logic [7:0]  attempt_number = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [10:0] frame_id;
	logic [3:0]  frame_length;
	logic [7:0]  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
	logic        last_frame;
	logic [31:0] timer_load;

	frame_scoreboard sb = new();

	int stall_pct = 0;
	int stall_left = 0;
	int gap_max = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	can_frame_segmenter dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_data              (cfg_data),
		.in_valid              (in_valid),
		.in_ready              (in_ready),
		.data_byte             (data_byte),
		.slave_address         (slave_address),
		.message_length        (message_length),
		.expected_reply_frames (expected_reply_frames),
		.attempt_number        (attempt_number),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.frame_id              (frame_id),
		.frame_length          (frame_length),
		.byte0                 (byte0),
		.byte1                 (byte1),
		.byte2                 (byte2),
		.byte3                 (byte3),
		.byte4                 (byte4),
		.byte5                 (byte5),
		.byte6                 (byte6),
		.byte7                 (byte7),
		.last_frame            (last_frame),
		.timer_load            (timer_load)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stall runs at a per-phase rate
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 5);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// frame monitor
	always @(posedge clk) begin : frame_monitor
		frame_rec_t got;
		if (arst_n && out_valid && out_ready) begin
			got.id     = frame_id;
			got.length = frame_length;
			got.data   = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
			got.last   = last_frame;
			got.timer  = timer_load;
			sb.check_frame(got);
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("** can_frame_segmenter: FAILED **");
			$finish;
		end
	end

	function automatic seg_byte_t mk(logic [7:0] data, logic [7:0] slave, logic [7:0] len,
			logic [15:0] reply, logic [7:0] attempt);
		seg_byte_t b;
		b.data    = data;
		b.slave   = slave;
		b.len     = len;
		b.reply   = reply;
		b.attempt = attempt;
		return b;
	endfunction

	// one byte transfer, with burst gaps in front
	task automatic send_byte(seg_byte_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid              <= 1'b1;
		data_byte             <= b.data;
		slave_address         <= b.slave;
		message_length        <= b.len;
		expected_reply_frames <= b.reply;
		attempt_number        <= b.attempt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b);
	endtask

	// stop sending and wait until every expected frame has come
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(bit fast);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= fast;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_rate(fast);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		// broadcast single frame, load saturates
		send_byte(mk(8'hFF, 8'h00, 8'd1, 16'hFFFF, 8'd1));
		// unicast single frame, back-off term only
		send_byte(mk(8'h00, 8'hFF, 8'd1, 16'h0000, 8'hFF));
		// zero length byte is dropped
		send_byte(mk(8'hA5, 8'h12, 8'd0, 16'h1234, 8'd3));
		// attempt zero behaves as attempt one
		send_byte(mk(8'h3C, 8'h01, 8'd1, 16'h0001, 8'd0));
		// first, continuation and a one-byte end frame
		for (int i = 0; i < 17; i++)
			send_byte(mk(8'(i * 15), 8'h7E, 8'd17, 16'd300, 8'd2));
		// length drops below the byte count: fourth byte closes the message
		for (int i = 0; i < 3; i++)
			send_byte(mk(8'(8'h80 + i), 8'h55, 8'd255, 16'd10, 8'd1));
		send_byte(mk(8'h99, 8'h55, 8'd2, 16'd10, 8'd1));
	endtask

	// random messages, mostly well formed, some cut short, some noise
	task automatic run_random(int target);
		int        taken;
		int        kind;
		int        sel;
		int        len;
		int        cut;
		seg_byte_t b;
		seg_byte_t z;
		taken = 0;
		while (taken < target) begin
			kind = $urandom_range(0, 99);
			sel = $urandom_range(0, 9);
			b.slave = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(1, 254));
			sel = $urandom_range(0, 3);
			b.reply = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'($urandom_range(0, 15)) :
				(sel == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 400));
			sel = $urandom_range(0, 5);
			b.attempt = (sel == 0) ? 8'd0 : (sel == 1) ? 8'hFF :
				(sel == 2) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 20));
			if (kind < 80) begin
				// well-formed message
				sel = $urandom_range(0, 99);
				if (sel < 3)
					len = $urandom_range(128, 255);
				else if (sel < 25)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(1, 16);
				b.len = 8'(len);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 3) begin
						z = b;
						z.len = 8'd0;
						z.data = 8'($urandom_range(0, 255));
						send_byte(z);
					end
					b.data = 8'($urandom_range(0, 255));
					send_byte(b);
					taken++;
				end
			end else if (kind < 90) begin
				// length shrinks mid-message
				len = $urandom_range(3, 40);
				cut = $urandom_range(1, len - 2);
				b.len = 8'(len);
				for (int i = 0; i < cut; i++) begin
					b.data = 8'($urandom_range(0, 255));
					send_byte(b);
				end
				b.len  = 8'($urandom_range(1, cut + 1));
				b.data = 8'($urandom_range(0, 255));
				send_byte(b);
				taken += cut + 1;
			end else if (kind < 95) begin
				// zero length noise
				b.len = 8'd0;
				repeat ($urandom_range(1, 3)) begin
					b.data = 8'($urandom_range(0, 255));
					send_byte(b);
				end
			end else begin
				settle_idle();
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fast rate, directed cases
		stall_pct = 30;
		gap_max   = 4;
		write_rate(1'b1);
		run_directed();
		settle_idle();

		// slow rate, back to back, receiver always ready
		stall_pct = 0;
		gap_max   = 0;
		write_rate(1'b0);
		run_random(220);
		settle_idle();

		// fast rate, heavy stalls and long gaps
		stall_pct = 50;
		gap_max   = 8;
		write_rate(1'b1);
		run_random(220);
		settle_idle();

		// slow rate, light idling
		stall_pct = 15;
		gap_max   = 3;
		write_rate(1'b0);
		run_random(190);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending_count() == 0)
			$display("** can_frame_segmenter: PASSED **");
		else
			$display("** can_frame_segmenter: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cfs_pkg.sv
rtl/core/cfs_assembler.sv
rtl/core/cfs_timer.sv
rtl/core/can_frame_segmenter.sv
dv/can_frame_segmenter_tb.sv
